@@ rtl/zigzag_count_matrix_power_top_defines.svh @@
// ----------------------------------------------------------------------------
// zigzag count matrix power - assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ZIGZAG_COUNT_MATRIX_POWER_TOP_DEFINES_SVH
`define ZIGZAG_COUNT_MATRIX_POWER_TOP_DEFINES_SVH

// same-cycle implication
`define ZCMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zcmp check failed");

// next-cycle implication
`define ZCMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zcmp check failed");

`endif

@@ rtl/zcmp_pkg.sv @@
// ----------------------------------------------------------------------------
// zcmp_pkg
// shared types and constants of the zigzag count matrix power block
// ----------------------------------------------------------------------------
`default_nettype none

package zcmp_pkg;

    localparam int MAX_VALUES_DEFAULT = 16;
    localparam int ELEM_W = 30;

    localparam logic [ELEM_W-1:0] MODULUS = 30'd1000000007;
    // floor(2^60 / modulus)
    localparam logic [30:0] BARRETT_M = 31'd1152921496;

    typedef struct packed {
        logic [30:0] array_length;
        logic [15:0] low_value;
        logic [15:0] high_value;
    } request_t;

    typedef struct packed {
        logic [29:0] count;
        logic        range_error;
    } result_t;

    typedef struct packed {
        logic first;
        logic last;
    } mac_tag_t;

endpackage

`default_nettype wire

@@ rtl/zcmp_mac.sv @@
// ----------------------------------------------------------------------------
// zcmp_mac
// pipelined modular multiply-accumulate: product, barrett reduction,
// running sum per output entry
// ----------------------------------------------------------------------------
`default_nettype none

module zcmp_mac #(
    parameter int AW = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire zcmp_pkg::mac_tag_t                in_tag,
    input  wire logic [AW-1:0]                     in_addr,
    input  wire logic [zcmp_pkg::ELEM_W-1:0]       a,
    input  wire logic [zcmp_pkg::ELEM_W-1:0]       b,
    output logic                                   busy,
    output logic                                   wr_valid,
    output logic [AW-1:0]                          wr_addr,
    output logic [zcmp_pkg::ELEM_W-1:0]            wr_data
);

    localparam int NS = 6;

    logic [NS-1:0]              v_reg;
    zcmp_pkg::mac_tag_t         tag_reg  [NS];
    logic [AW-1:0]              addr_reg [NS];

    logic [59:0]                prod_reg;
    logic [30:0]                q_reg;
    logic [31:0]                plow2_reg;
    logic [31:0]                plow3_reg;
    logic [31:0]                qp_reg;
    logic [31:0]                r4_reg;
    logic [31:0]                r5_reg;
    logic [29:0]                r6_reg;
    logic [29:0]                acc_reg;
    logic [29:0]                acc_next;
    logic                       wr_valid_reg;
    logic [AW-1:0]              wr_addr_reg;

    logic [61:0]                qfull;
    logic [60:0]                qpfull;
    logic [30:0]                sum;

    assign qfull  = 62'(prod_reg[59:29]) * 62'(zcmp_pkg::BARRETT_M);
    assign qpfull = 61'(q_reg) * 61'(zcmp_pkg::MODULUS);

    always_comb
    begin
        sum = (tag_reg[NS-1].first ? 31'd0 : 31'(acc_reg)) + 31'(r6_reg);
        if (sum >= 31'(zcmp_pkg::MODULUS))
        begin
            acc_next = 30'(sum - 31'(zcmp_pkg::MODULUS));
        end
        else
        begin
            acc_next = sum[29:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg        <= {v_reg[NS-2:0], in_valid};
            wr_valid_reg <= v_reg[NS-1] && tag_reg[NS-1].last;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0]  <= in_tag;
        addr_reg[0] <= in_addr;
        for (int s = 1; s < NS; s++)
        begin
            tag_reg[s]  <= tag_reg[s-1];
            addr_reg[s] <= addr_reg[s-1];
        end
        prod_reg  <= 60'(a) * 60'(b);
        q_reg     <= qfull[61:31];
        plow2_reg <= prod_reg[31:0];
        qp_reg    <= qpfull[31:0];
        plow3_reg <= plow2_reg;
        r4_reg    <= plow3_reg - qp_reg;
        r5_reg    <= (r4_reg >= 32'(zcmp_pkg::MODULUS)) ?
                     r4_reg - 32'(zcmp_pkg::MODULUS) : r4_reg;
        r6_reg    <= (r5_reg >= 32'(zcmp_pkg::MODULUS)) ?
                     30'(r5_reg - 32'(zcmp_pkg::MODULUS)) : r5_reg[29:0];
        if (v_reg[NS-1])
        begin
            acc_reg <= acc_next;
        end
        wr_addr_reg <= addr_reg[NS-1];
    end

    assign busy     = (|v_reg) || wr_valid_reg;
    assign wr_valid = wr_valid_reg;
    assign wr_addr  = wr_addr_reg;
    assign wr_data  = acc_reg;

endmodule

`default_nettype wire

@@ rtl/zigzag_count_matrix_power_top.sv @@
// ----------------------------------------------------------------------------
// zigzag_count_matrix_power_top
// counts zigzag arrays mod 1000000007 by powering a 2V x 2V transition
// matrix held in on-chip memories
// ----------------------------------------------------------------------------
//  channel   payload     handshake                 direction
//  request   request_t   request_valid/stall       in
//  result    result_t    result_valid/stall        out
//
//  one request at a time; V values give S = 2V matrix size
//  an S*S init pass, then one product per square and per set exponent
//  bit (S^3 multiply-accumulates and an S*S copy each), S*S final sum;
//  the MAC pipeline takes one multiply-accumulate per cycle
//  range errors go straight to the result; no clearing pass after reset
//  result stall holds the result register; a new request is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_count_matrix_power_top #(
    parameter int MAX_VALUES = zcmp_pkg::MAX_VALUES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               request_valid,
    output logic                    request_stall,
    input  wire zcmp_pkg::request_t request,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output zcmp_pkg::result_t       result
);

    localparam int DIM   = 2 * MAX_VALUES;
    localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam int EW    = zcmp_pkg::ELEM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_NEXT, S_MUL, S_DRAIN, S_COPY, S_COPYW,
        S_SUM, S_SUMW, S_FINISH
    } state_t;

    typedef enum logic {
        OP_POW, OP_SQ
    } op_t;

    logic [EW-1:0] power_mem   [DEPTH];
    logic [EW-1:0] base_mem    [DEPTH];
    logic [EW-1:0] scratch_mem [DEPTH];

    state_t            state_reg;
    op_t               op_reg;
    logic [IW-1:0]     i_reg, j_reg, k_reg, m1_reg, v_reg;
    logic [30:0]       exp_reg;
    logic              pow_done_reg;
    logic              err_reg;
    logic [EW-1:0]     total_reg;
    logic              rd_v_reg;
    zcmp_pkg::mac_tag_t rd_tag_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              cp_v_reg;
    logic [AW-1:0]     cp_addr_reg;
    logic              sum_v_reg;
    logic              result_valid_reg;
    zcmp_pkg::result_t result_reg;

    logic [EW-1:0]     power_rd_reg, base_a_rd_reg, base_b_rd_reg, scratch_rd_reg;

    logic [16:0]       span;
    logic              req_err;
    logic              accept;
    logic              init_bit;
    logic [AW-1:0]     ij_addr, ik_addr, kj_addr, pw_raddr;
    logic              ij_last;
    logic [EW:0]       tsum;

    logic              pw_we, bs_we;
    logic [AW-1:0]     pw_waddr, bs_waddr;
    logic [EW-1:0]     pw_wdata, bs_wdata;

    logic              mac_busy, mac_wr_valid;
    logic [AW-1:0]     mac_wr_addr;
    logic [EW-1:0]     mac_wr_data;
    zcmp_pkg::mac_tag_t issue_tag;

    assign accept  = request_valid && !request_stall;
    assign span    = {1'b0, request.high_value} - {1'b0, request.low_value};
    assign req_err = (request.high_value < request.low_value) ||
                     (span >= 17'(MAX_VALUES));

    assign ij_addr  = {i_reg, j_reg};
    assign ik_addr  = {i_reg, k_reg};
    assign kj_addr  = {k_reg, j_reg};
    assign pw_raddr = (state_reg == S_SUM) ? ij_addr : ik_addr;
    assign ij_last  = (i_reg == m1_reg) && (j_reg == m1_reg);
    assign tsum     = {1'b0, total_reg} + {1'b0, power_rd_reg};

    assign issue_tag.first = (k_reg == '0);
    assign issue_tag.last  = (k_reg == m1_reg);

    always_comb
    begin
        init_bit = ((i_reg >= v_reg) && (j_reg < v_reg) && ((i_reg - v_reg) < j_reg)) ||
                   ((i_reg < v_reg) && (j_reg >= v_reg) && (i_reg > (j_reg - v_reg)));
        pw_we    = 1'b0;
        bs_we    = 1'b0;
        pw_waddr = ij_addr;
        bs_waddr = ij_addr;
        pw_wdata = (i_reg == j_reg) ? EW'(1) : '0;
        bs_wdata = init_bit ? EW'(1) : '0;
        if (state_reg == S_INIT)
        begin
            pw_we = 1'b1;
            bs_we = 1'b1;
        end
        else if (cp_v_reg)
        begin
            pw_we    = (op_reg == OP_POW);
            bs_we    = (op_reg == OP_SQ);
            pw_waddr = cp_addr_reg;
            bs_waddr = cp_addr_reg;
            pw_wdata = scratch_rd_reg;
            bs_wdata = scratch_rd_reg;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (pw_we)
        begin
            power_mem[pw_waddr] <= pw_wdata;
        end
        power_rd_reg <= power_mem[pw_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bs_we)
        begin
            base_mem[bs_waddr] <= bs_wdata;
        end
        base_a_rd_reg <= base_mem[ik_addr];
        base_b_rd_reg <= base_mem[kj_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mac_wr_valid)
        begin
            scratch_mem[mac_wr_addr] <= mac_wr_data;
        end
        scratch_rd_reg <= scratch_mem[ij_addr];
    end

    zcmp_mac #(
        .AW (AW)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_v_reg),
        .in_tag   (rd_tag_reg),
        .in_addr  (rd_addr_reg),
        .a        ((op_reg == OP_SQ) ? base_a_rd_reg : power_rd_reg),
        .b        (base_b_rd_reg),
        .busy     (mac_busy),
        .wr_valid (mac_wr_valid),
        .wr_addr  (mac_wr_addr),
        .wr_data  (mac_wr_data)
    );

    always_ff @(posedge clk)
    begin
        rd_tag_reg  <= issue_tag;
        rd_addr_reg <= ij_addr;
        cp_addr_reg <= ij_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_POW;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            m1_reg           <= '0;
            v_reg            <= '0;
            exp_reg          <= '0;
            pow_done_reg     <= 1'b0;
            err_reg          <= 1'b0;
            total_reg        <= '0;
            rd_v_reg         <= 1'b0;
            cp_v_reg         <= 1'b0;
            sum_v_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            rd_v_reg  <= (state_reg == S_MUL);
            cp_v_reg  <= (state_reg == S_COPY);
            sum_v_reg <= (state_reg == S_SUM);
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end
            if (sum_v_reg)
            begin
                total_reg <= (tsum >= (EW+1)'(zcmp_pkg::MODULUS)) ?
                             EW'(tsum - (EW+1)'(zcmp_pkg::MODULUS)) : tsum[EW-1:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        i_reg        <= '0;
                        j_reg        <= '0;
                        k_reg        <= '0;
                        v_reg        <= IW'(span + 17'd1);
                        m1_reg       <= IW'({span, 1'b1});
                        exp_reg      <= (request.array_length == '0) ? '0 :
                                        request.array_length - 31'd1;
                        pow_done_reg <= 1'b0;
                        err_reg      <= req_err;
                        total_reg    <= '0;
                        state_reg    <= req_err ? S_FINISH : S_INIT;
                    end
                end
                S_INIT, S_COPY, S_SUM:
                begin
                    if (ij_last)
                    begin
                        j_reg <= '0;
                        i_reg <= '0;
                        case (state_reg)
                            S_INIT:  state_reg <= S_NEXT;
                            S_COPY:  state_reg <= S_COPYW;
                            default: state_reg <= S_SUMW;
                        endcase
                    end
                    else if (j_reg == m1_reg)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + IW'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                S_NEXT:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    k_reg <= '0;
                    if (exp_reg[0] && !pow_done_reg)
                    begin
                        op_reg    <= OP_POW;
                        state_reg <= S_MUL;
                    end
                    else if (exp_reg[30:1] == '0)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        op_reg    <= OP_SQ;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (k_reg == m1_reg)
                    begin
                        k_reg <= '0;
                        if (j_reg == m1_reg)
                        begin
                            j_reg <= '0;
                            if (i_reg == m1_reg)
                            begin
                                i_reg     <= '0;
                                state_reg <= S_DRAIN;
                            end
                            else
                            begin
                                i_reg <= i_reg + IW'(1);
                            end
                        end
                        else
                        begin
                            j_reg <= j_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + IW'(1);
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_v_reg && !mac_busy)
                    begin
                        state_reg <= S_COPY;
                    end
                end
                S_COPYW:
                begin
                    if (op_reg == OP_POW)
                    begin
                        pow_done_reg <= 1'b1;
                    end
                    else
                    begin
                        exp_reg      <= exp_reg >> 1;
                        pow_done_reg <= 1'b0;
                    end
                    state_reg <= S_NEXT;
                end
                S_SUMW:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.count       <= err_reg ? '0 : total_reg;
                        result_reg.range_error <= err_reg;
                        result_valid_reg       <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

endmodule

`default_nettype wire

@@ rtl/zcmp_checker.sv @@
// ----------------------------------------------------------------------------
// zcmp_checker
// port-level checks of the zigzag count matrix power block
// ----------------------------------------------------------------------------
`default_nettype none

`include "zigzag_count_matrix_power_top_defines.svh"

module zcmp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               request_valid,
    input wire logic               request_stall,
    input wire zcmp_pkg::request_t request,
    input wire logic               result_valid,
    input wire logic               result_stall,
    input wire zcmp_pkg::result_t  result
);

    logic unused_req;
    assign unused_req = request_valid ^ (|request);

    `ZCMP_ASSERT_NEXT(a_res_hold, result_valid && result_stall, result_valid)
    `ZCMP_ASSERT_NEXT(a_res_stable, result_valid && result_stall, $stable(result))
    `ZCMP_ASSERT_NOW(a_err_zero, result_valid && result.range_error, result.count == '0)
    `ZCMP_ASSERT_NOW(a_count_mod, result_valid, result.count < zcmp_pkg::MODULUS)
    `ZCMP_ASSERT_NEXT(a_busy_after, request_valid && !request_stall, request_stall)

endmodule

bind zigzag_count_matrix_power_top zcmp_checker u_zcmp_checker (.*);

`default_nettype wire
